/* rtl/core/kti_pkg.sv */
// ----------------------------------------------------------------------------
// kti_pkg : shared types and constants for the keyframe track interpolator
// Widths of the request and response fields, controller command and
// datapath status structures.
// ----------------------------------------------------------------------------
package kti_pkg;

   localparam int MAX_KEYS    = 64;
   localparam int SLOT_W      = $clog2(MAX_KEYS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int TIME_W      = 32;
   localparam int VAL_W       = 32;
   localparam int NUM_COMP    = 3;
   localparam int KEY_W       = NUM_COMP * VAL_W;
   localparam int COMP_W      = 2;
   localparam int BLEND_BITS  = 16;
   localparam int BLEND_W     = BLEND_BITS + 1;
   localparam int DIV_CNT_W   = $clog2(BLEND_BITS);
   localparam int DIFF_W      = VAL_W + 1;
   localparam int PROD_W      = DIFF_W + BLEND_W + 1;

   localparam int REQ_USED_W  = SLOT_W + TIME_W + KEY_W;
   localparam int REQ_DATA_W  = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_USED_W  = KEY_W + SLOT_W + BLEND_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_USED_W;

   localparam logic REQ_FUNC_LOAD  = 1'b0;
   localparam logic REQ_FUNC_QUERY = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic                 wr_en;
      logic                 start;
      logic [SLOT_W-1:0]    rd_addr;
      logic [SLOT_W-1:0]    seg;
      logic                 cap_a;
      logic                 cap_b;
      logic                 prep;
      logic                 norm;
      logic                 classify;
      logic                 div_step;
      logic                 ldiff;
      logic                 single;
      logic                 mul;
      logic                 acc;
      logic [COMP_W-1:0]    comp;
      logic                 out_load;
   } kti_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic t_before;
      logic need_div;
   } kti_sts_type;

endpackage

/* rtl/core/keyframe_track_interpolator_top.sv */
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_top : linear keyframe interpolation, one track
// Holds up to 64 timed 3-component keys and answers time queries with the
// linearly blended value of the enclosing segment.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one request: tuser = 0 loads a key (slot, time, x, y, z),
//   tuser = 1 queries the track at req time. Loads give no response.
//   rsp_* returns one response per query: x, y, z, segment index, blend.
//   csr_we / csr_wdata set the key count; write only while the block is idle.
// Timing
//   A load is written to the key stores as it is taken. A query scans 1 to key
//   count - 1 key times, read one by one from the single read port of the time
//   store; a restoring divide then forms the blend one quotient bit at a time
//   (skipped when it clamps to 0 or one), and one shared multiplier blends the
//   three components in turn. The next request can be taken in the cycle after
//   the response is registered, even while that response still waits at the
//   output register.
// Reset
//   Synchronous, active high: control returns to idle, no response pending,
//   key count back to one. Key stores are not cleared.
// Stall
//   A held-off response stays stable in its register; a finished query waits
//   until that register is free.
// ----------------------------------------------------------------------------
module keyframe_track_interpolator_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // key_slot, time_ticks, val_x, val_y, val_z (lowest bit up)
   input  logic [kti_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic                             req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_x, out_y, out_z, segment_index, blend_factor (lowest bit up)
   output logic [kti_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // key count register
   input  logic                             csr_we,
   input  logic [kti_pkg::CNT_W-1:0]        csr_wdata
);

   localparam int SW = kti_pkg::SLOT_W;
   localparam int TW = kti_pkg::TIME_W;

   logic [kti_pkg::CNT_W-1:0]   key_count_ff;
   kti_pkg::kti_cmd_type        cmd;
   kti_pkg::kti_sts_type        sts;
   logic [kti_pkg::KEY_W-1:0]   out_vals;
   logic [SW-1:0]               out_seg;
   logic [kti_pkg::BLEND_W-1:0] out_blend;

   // key count, reset to a single key
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kti_pkg::CNT_W'(1);
      end else if (csr_we) begin
         key_count_ff <= csr_wdata;
      end
   end

   kti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .key_count  (key_count_ff),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   // request fields unpacked straight from tdata
   kti_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .wr_slot   (req_tdata[SW-1:0]),
      .req_time  (req_tdata[SW+TW-1:SW]),
      .req_vals  (req_tdata[kti_pkg::REQ_USED_W-1:SW+TW]),
      .sts       (sts),
      .out_vals  (out_vals),
      .out_seg   (out_seg),
      .out_blend (out_blend)
   );

   assign rsp_tdata = {{kti_pkg::RSP_PAD_W{1'b0}}, out_blend, out_seg, out_vals};

endmodule

/* rtl/core/kti_ram.sv */
// ----------------------------------------------------------------------------
// kti_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/kti_dp.sv */
// ----------------------------------------------------------------------------
// kti_dp : datapath of the keyframe track interpolator
// Key stores, segment times, restoring divider for the blend factor,
// shared multiplier for the three components and the response register.
// ----------------------------------------------------------------------------
module kti_dp (
   input  logic                          clock,
   input  kti_pkg::kti_cmd_type          cmd,
   input  logic [kti_pkg::SLOT_W-1:0]    wr_slot,
   input  logic [kti_pkg::TIME_W-1:0]    req_time,
   input  logic [kti_pkg::KEY_W-1:0]     req_vals,
   output kti_pkg::kti_sts_type          sts,
   output logic [kti_pkg::KEY_W-1:0]     out_vals,
   output logic [kti_pkg::SLOT_W-1:0]    out_seg,
   output logic [kti_pkg::BLEND_W-1:0]   out_blend
);

   localparam int VW = kti_pkg::VAL_W;
   localparam int DW = kti_pkg::DIFF_W;
   localparam int BB = kti_pkg::BLEND_BITS;

   logic [kti_pkg::TIME_W-1:0]  time_rd;
   logic [kti_pkg::KEY_W-1:0]   val_rd;

   logic [kti_pkg::TIME_W-1:0]  t_ff;
   logic [kti_pkg::TIME_W-1:0]  t0_ff;
   logic [kti_pkg::TIME_W-1:0]  t1_ff;
   logic [VW-1:0]               a_ff [kti_pkg::NUM_COMP];
   logic [VW-1:0]               b_ff [kti_pkg::NUM_COMP];
   logic [DW-1:0]               num_ff;
   logic [DW-1:0]               den_ff;
   logic [kti_pkg::BLEND_W-1:0] f_ff;
   logic signed [DW-1:0]        diff_ff [kti_pkg::NUM_COMP];
   logic signed [kti_pkg::PROD_W-1:0] prod_ff;
   logic [VW-1:0]               res_ff [kti_pkg::NUM_COMP];
   logic [kti_pkg::KEY_W-1:0]   out_vals_ff;
   logic [kti_pkg::SLOT_W-1:0]  out_seg_ff;
   logic [kti_pkg::BLEND_W-1:0] out_blend_ff;

   logic                        num_pos;
   logic                        den_zero;
   logic [DW-1:0]               rem_shift;
   logic                        rem_ge;

   kti_ram #(
      .WIDTH (kti_pkg::TIME_W),
      .DEPTH (kti_pkg::MAX_KEYS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_slot),
      .wr_data (req_time),
      .rd_addr (cmd.rd_addr),
      .rd_data (time_rd)
   );

   kti_ram #(
      .WIDTH (kti_pkg::KEY_W),
      .DEPTH (kti_pkg::MAX_KEYS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_slot),
      .wr_data (req_vals),
      .rd_addr (cmd.rd_addr),
      .rd_data (val_rd)
   );

   // den is non-negative once normalised; num may still be negative
   assign num_pos   = !num_ff[DW-1] && (num_ff != '0);
   assign den_zero  = (den_ff == '0);
   assign rem_shift = {num_ff[DW-2:0], 1'b0};
   assign rem_ge    = (rem_shift >= den_ff);

   assign sts.t_before = (t_ff < time_rd);
   assign sts.need_div = !den_zero && num_pos && (num_ff < den_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         t_ff <= req_time;
         f_ff <= '0;
      end
      if (cmd.cap_a) begin
         t0_ff <= time_rd;
         for (int c = 0; c < kti_pkg::NUM_COMP; c++) begin
            a_ff[c] <= val_rd[c*VW +: VW];
         end
      end
      if (cmd.cap_b) begin
         t1_ff <= time_rd;
         for (int c = 0; c < kti_pkg::NUM_COMP; c++) begin
            b_ff[c] <= val_rd[c*VW +: VW];
         end
      end
      if (cmd.prep) begin
         num_ff <= {1'b0, t_ff} - {1'b0, t0_ff};
         den_ff <= {1'b0, t1_ff} - {1'b0, t0_ff};
      end
      // descending key times: flip both signs
      if (cmd.norm && den_ff[DW-1]) begin
         num_ff <= -num_ff;
         den_ff <= -den_ff;
      end
      if (cmd.classify) begin
         if (!den_zero && num_pos && !sts.need_div) begin
            f_ff <= kti_pkg::BLEND_W'(1 << BB);
         end else begin
            f_ff <= '0;
         end
      end
      // one quotient bit per cycle, remainder kept in num_ff
      if (cmd.div_step) begin
         num_ff <= rem_ge ? (rem_shift - den_ff) : rem_shift;
         f_ff   <= {f_ff[kti_pkg::BLEND_W-2:0], rem_ge};
      end
      if (cmd.ldiff) begin
         for (int c = 0; c < kti_pkg::NUM_COMP; c++) begin
            diff_ff[c] <= cmd.single ? '0 :
                          ($signed({b_ff[c][VW-1], b_ff[c]}) -
                           $signed({a_ff[c][VW-1], a_ff[c]}));
         end
      end
      if (cmd.mul) begin
         prod_ff <= kti_pkg::PROD_W'(diff_ff[cmd.comp]) *
                    kti_pkg::PROD_W'($signed({1'b0, f_ff}));
      end
      // arithmetic shift: floor of prod / 2^16
      if (cmd.acc) begin
         res_ff[cmd.comp] <= a_ff[cmd.comp] + prod_ff[BB+VW-1:BB];
      end
      if (cmd.out_load) begin
         out_vals_ff  <= {res_ff[2], res_ff[1], res_ff[0]};
         out_seg_ff   <= cmd.seg;
         out_blend_ff <= f_ff;
      end
   end

   assign out_vals  = out_vals_ff;
   assign out_seg   = out_seg_ff;
   assign out_blend = out_blend_ff;

endmodule

/* rtl/core/kti_ctrl.sv */
// ----------------------------------------------------------------------------
// kti_ctrl : controller of the keyframe track interpolator
// Sequences the key scan, segment fetch, divide and blend of a request,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module kti_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_func,
   input  logic [kti_pkg::CNT_W-1:0]   key_count,
   input  logic                        rsp_tready,
   input  kti_pkg::kti_sts_type        sts,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   output kti_pkg::kti_cmd_type        cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_PREP,
      ST_NORM,
      ST_CLASS,
      ST_DIV,
      ST_LDIFF,
      ST_MUL,
      ST_ACC,
      ST_PUSH
   } state_type;

   state_type                      state_ff;
   logic [kti_pkg::SLOT_W-1:0]     idx_ff;
   logic [kti_pkg::SLOT_W-1:0]     seg_ff;
   logic                           single_ff;
   logic [kti_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [kti_pkg::COMP_W-1:0]     comp_ff;
   logic                           rsp_valid_ff;

   logic [kti_pkg::CNT_W-1:0]      n_keys;
   logic                           accept;

   // zero counts as one, anything beyond the store saturates
   always_comb begin
      if (key_count == '0) begin
         n_keys = kti_pkg::CNT_W'(1);
      end else if (key_count > kti_pkg::CNT_W'(kti_pkg::MAX_KEYS)) begin
         n_keys = kti_pkg::CNT_W'(kti_pkg::MAX_KEYS);
      end else begin
         n_keys = key_count;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.rd_addr = idx_ff + kti_pkg::SLOT_W'(1);
      cmd.seg     = seg_ff;
      cmd.single  = single_ff;
      cmd.comp    = comp_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.wr_en = accept && (req_func == kti_pkg::REQ_FUNC_LOAD);
            cmd.start = accept && (req_func == kti_pkg::REQ_FUNC_QUERY);
         end
         ST_FETCH0: begin
            cmd.rd_addr = seg_ff;
         end
         ST_FETCH1: begin
            cmd.cap_a   = 1'b1;
            cmd.rd_addr = seg_ff + kti_pkg::SLOT_W'(1);
         end
         ST_FETCH2: cmd.cap_b    = 1'b1;
         ST_PREP:   cmd.prep     = 1'b1;
         ST_NORM:   cmd.norm     = 1'b1;
         ST_CLASS:  cmd.classify = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_LDIFF:  cmd.ldiff    = 1'b1;
         ST_MUL:    cmd.mul      = 1'b1;
         ST_ACC:    cmd.acc      = 1'b1;
         ST_PUSH: begin
            cmd.out_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_func == kti_pkg::REQ_FUNC_QUERY)) begin
                  idx_ff <= '0;
                  seg_ff <= '0;
                  if (n_keys == kti_pkg::CNT_W'(1)) begin
                     single_ff <= 1'b1;
                     state_ff  <= ST_FETCH0;
                  end else begin
                     single_ff <= 1'b0;
                     state_ff  <= ST_SCAN_RD;
                  end
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_CMP;
            ST_SCAN_CMP: begin
               if (sts.t_before) begin
                  seg_ff   <= idx_ff;
                  state_ff <= ST_FETCH0;
               end else if (({1'b0, idx_ff} + kti_pkg::CNT_W'(2)) == n_keys) begin
                  seg_ff   <= '0;
                  state_ff <= ST_FETCH0;
               end else begin
                  idx_ff   <= idx_ff + kti_pkg::SLOT_W'(1);
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_FETCH0: state_ff <= ST_FETCH1;
            ST_FETCH1: state_ff <= single_ff ? ST_LDIFF : ST_FETCH2;
            ST_FETCH2: state_ff <= ST_PREP;
            ST_PREP:   state_ff <= ST_NORM;
            ST_NORM:   state_ff <= ST_CLASS;
            ST_CLASS: begin
               cnt_ff   <= '0;
               state_ff <= sts.need_div ? ST_DIV : ST_LDIFF;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + kti_pkg::DIV_CNT_W'(1);
               if (cnt_ff == kti_pkg::DIV_CNT_W'(kti_pkg::BLEND_BITS - 1)) begin
                  state_ff <= ST_LDIFF;
               end
            end
            ST_LDIFF: begin
               comp_ff  <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               if (comp_ff == kti_pkg::COMP_W'(kti_pkg::NUM_COMP - 1)) begin
                  state_ff <= ST_PUSH;
               end else begin
                  comp_ff  <= comp_ff + kti_pkg::COMP_W'(1);
                  state_ff <= ST_MUL;
               end
            end
            ST_PUSH: begin
               if (cmd.out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten while stalled");

   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.start) |=> (state_ff != ST_IDLE))
      else $error("query request not started");

   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH2) |-> (({1'b0, seg_ff} + kti_pkg::CNT_W'(1)) < n_keys))
      else $error("segment end beyond key count");

   a_single_seg_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH0 && single_ff) |-> (seg_ff == '0))
      else $error("single key track not on segment zero");

endmodule
